// File: sv/signed_integer_to_ascii_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef SIGNED_INTEGER_TO_ASCII_MACROS_SVH
`define SIGNED_INTEGER_TO_ASCII_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SITA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sita assertion failed");

// Next-cycle implication, off while reset is high.
`define SITA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sita assertion failed");

`endif

// File: sv/sita_pkg.sv
package sita_pkg;

  // ASCII codes and digit constants
  localparam logic [6:0] ASCII_ZERO        = 7'd48;
  localparam logic [6:0] ASCII_LETTER_BIAS = 7'd87;
  localparam logic [6:0] ASCII_MINUS       = 7'd45;
  localparam logic [6:0] ASCII_X           = 7'd120;
  localparam logic [3:0] DEC_LIMIT         = 4'd9;
  localparam logic [3:0] DABBLE_LIMIT      = 4'd4;
  localparam logic [3:0] DABBLE_ADD        = 4'd3;

  // Register index of radix_mode
  localparam logic REG_RADIX_MODE = 1'b0;

  // Which character the output stage produces
  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      ptr_dec;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic ptr_zero;
    logic negative;
  } dp_status_t;

endpackage

// File: sv/signed_integer_to_ascii.sv
// Channel   Ports                                        Transfer
// input     start, busy, value                           start high and busy low
// result    valid, character, last                       valid high, one cycle
// config    psel, penable, pwrite, paddr, pwdata, ...    psel & penable & pwrite
//
// Decimal: a load step, a double-dabble shift step per value bit, one trim step
// per leading zero slot plus one, then the characters.
// Hex: a load step, trim, then the characters (no shift loop).
// Results are registered from each emit step; the last one overlaps idle.
// rst is synchronous and clears the controller, strobe and radix_mode.
// The receiver cannot stall: each character is shown for exactly one cycle.
`include "signed_integer_to_ascii_macros.svh"

module signed_integer_to_ascii
  import sita_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   valid,
  output logic [6:0]             character,
  output logic                   last,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic       radix_mode;
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIX_MODE) ? {31'd0, radix_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX_MODE)) begin
      radix_mode <= pwdata[0];
    end
  end

  sita_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .radix_mode (radix_mode),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  sita_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .radix_mode (radix_mode),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .character  (character),
    .last       (last),
    .valid      (valid)
  );

  // Checks
  `SITA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SITA_ASSERT_NEXT(a_last_gap, clk, rst, valid && last, !valid)
  `SITA_ASSERT_SAME(a_valid_from_busy, clk, rst, valid, $past(busy))
  `SITA_ASSERT_SAME(a_emit_only_busy, clk, rst, cmd.emit, busy)

endmodule

// File: sv/sita_datapath.sv
module sita_datapath
  import sita_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   radix_mode,
  input  logic [VALUE_WIDTH-1:0] value,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             stat,
  output logic [6:0]             character,
  output logic                   last,
  output logic                   valid
);

  // Decimal digits of 2^VALUE_WIDTH - 1; always covers the hex digits too
  localparam int SLOTS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int SW    = SLOTS * 4;
  localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   negative;
  logic [SW-1:0]          slots;
  logic [CW-1:0]          bit_cnt;
  logic [PW-1:0]          ptr;

  logic [VALUE_WIDTH-1:0] mag_in;
  logic [SW-1:0]          corrected;
  logic [3:0]             cur;
  logic [6:0]             digit_char;

  // Absolute value; the most negative input maps onto itself, read unsigned
  assign mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  // Double-dabble correction: each BCD digit above 4 gets 3 added
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      corrected[i*4 +: 4] = (slots[i*4 +: 4] > DABBLE_LIMIT) ?
                            slots[i*4 +: 4] + DABBLE_ADD : slots[i*4 +: 4];
    end
  end

  assign cur        = slots[ptr*4 +: 4];
  assign digit_char = (cur > DEC_LIMIT) ? 7'(cur) + ASCII_LETTER_BIAS
                                        : 7'(cur) + ASCII_ZERO;

  // Status back to the controller
  assign stat.conv_done = (bit_cnt == CW'(VALUE_WIDTH - 1));
  assign stat.lead_zero = (ptr != '0) && (cur == 4'd0);
  assign stat.ptr_zero  = (ptr == '0);
  assign stat.negative  = negative;

  // Magnitude, sign, digit slots and conversion counters
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude <= '0;
      bit_cnt   <= '0;
      ptr       <= '0;
      negative  <= 1'b0;
    end else if (cmd.load) begin
      magnitude <= mag_in;
      negative  <= value[VALUE_WIDTH-1];
      slots     <= radix_mode ? SW'(mag_in) : '0;
      bit_cnt   <= '0;
      ptr       <= PW'(SLOTS - 1);
    end else if (cmd.conv_step) begin
      slots     <= {corrected[SW-2:0], magnitude[VALUE_WIDTH-1]};
      magnitude <= {magnitude[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt   <= bit_cnt + 1'b1;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - 1'b1;
    end
  end

  // Output register: one transfer per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      case (cmd.sel)
        SEL_MINUS: character <= ASCII_MINUS;
        SEL_ZERO:  character <= ASCII_ZERO;
        SEL_X:     character <= ASCII_X;
        SEL_DIGIT: character <= digit_char;
        default:   character <= digit_char;
      endcase
    end
  end

endmodule

// File: sv/sita_ctrl.sv
module sita_ctrl
  import sita_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       radix_mode,
  input  dp_status_t stat,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    TRIM,
    SIGN,
    PFX0,
    PFXX,
    DIGIT
  } state_t;

  state_t state, state_next;

  assign busy = (state != IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.ptr_dec   = 1'b0;
    cmd.emit      = 1'b0;
    cmd.sel       = SEL_DIGIT;
    cmd.last      = 1'b0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = radix_mode ? TRIM : CONV;
        end
      end
      CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_done) begin
          state_next = TRIM;
        end
      end
      TRIM: begin
        // drop leading zero digits, keep at least one
        if (stat.lead_zero) begin
          cmd.ptr_dec = 1'b1;
        end else if (stat.negative) begin
          state_next = SIGN;
        end else begin
          state_next = radix_mode ? PFX0 : DIGIT;
        end
      end
      SIGN: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_MINUS;
        state_next = radix_mode ? PFX0 : DIGIT;
      end
      PFX0: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_ZERO;
        state_next = PFXX;
      end
      PFXX: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_X;
        state_next = DIGIT;
      end
      DIGIT: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_DIGIT;
        cmd.last = stat.ptr_zero;
        if (stat.ptr_zero) begin
          state_next = IDLE;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
